>>> src/remc_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder menu controller package
// Shared types, constants and scaling functions.
// ----------------------------------------------------------------------------
`default_nettype none

package remc_pkg;

   localparam int unsigned LEVEL_W  = 7;
   localparam int unsigned COUNT_W  = 17;
   localparam int unsigned BCD_W    = 12;
   localparam int unsigned GAIN_W   = 8;
   localparam int unsigned DELAY_W  = 15;

   localparam logic [LEVEL_W-1:0] STEP_SIZE  = 7'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
   localparam logic [LEVEL_W-1:0] LEVEL_MIX_RST    = 7'd50;
   localparam logic [LEVEL_W-1:0] LEVEL_LENGTH_RST = 7'd50;
   localparam logic [LEVEL_W-1:0] LEVEL_ECHO_RST   = 7'd0;
   localparam logic [COUNT_W-1:0] BLINK_HALF_RST   = 17'd120000;

   // level*255/100 as one multiply by 255*ceil(2^19/100), then shift by 19
   localparam logic [27:0] GAIN_RECIP   = 28'd1336965;
   localparam int unsigned GAIN_SHIFT   = 19;
   localparam logic [15:0] DELAY_SCALE  = 16'd327;
   // x/10 for x below 1000 as (x*205) >> 11
   localparam logic [14:0] TENTH_RECIP  = 15'd205;

   localparam logic [2:0] LED_MIX    = 3'b001;
   localparam logic [2:0] LED_LENGTH = 3'b010;
   localparam logic [2:0] LED_ECHO   = 3'b100;
   localparam logic [2:0] LED_OFF    = 3'b000;

   typedef enum logic [2:0] {
      MODE_CTRL_MIX    = 3'd0,
      MODE_SEL_MIX     = 3'd1,
      MODE_SEL_LENGTH  = 3'd2,
      MODE_CTRL_LENGTH = 3'd3,
      MODE_SEL_ECHO    = 3'd4,
      MODE_CTRL_ECHO   = 3'd5
   } mode_type;

   // Menu state after one poll, as seen by the output formatter
   typedef struct packed {
      mode_type             mode;
      logic [LEVEL_W-1:0]   mix_level;
      logic [LEVEL_W-1:0]   length_level;
      logic [LEVEL_W-1:0]   echo_level;
      logic                 blink_phase;
      logic                 updated;
   } view_type;

   // One formatted result
   typedef struct packed {
      logic [2:0]           mode_code;
      logic [2:0]           led_pattern;
      logic [BCD_W-1:0]     display_bcd;
      logic [GAIN_W-1:0]    mix_gain;
      logic [GAIN_W-1:0]    echo_gain;
      logic [DELAY_W-1:0]   delay_samples;
      logic                 params_updated;
   } result_type;

   function automatic logic is_select(input mode_type m);
      is_select = (m == MODE_SEL_MIX) || (m == MODE_SEL_LENGTH) || (m == MODE_SEL_ECHO);
   endfunction

   function automatic logic [GAIN_W-1:0] gain_of(input logic [LEVEL_W-1:0] lvl);
      logic [27:0] prod;
      prod = 28'(lvl) * GAIN_RECIP;
      gain_of = prod[GAIN_SHIFT +: GAIN_W];
   endfunction

   function automatic logic [DELAY_W-1:0] delay_of(input logic [LEVEL_W-1:0] lvl);
      logic [15:0] prod;
      prod = 16'(lvl) * DELAY_SCALE;
      delay_of = prod[DELAY_W-1:0];
   endfunction

   function automatic logic [BCD_W-1:0] bcd_of(input logic [LEVEL_W-1:0] lvl);
      logic                hund;
      logic [LEVEL_W-1:0]  rem;
      logic [14:0]         prod;
      logic [3:0]          tens;
      logic [LEVEL_W-1:0]  ones;
      hund = (lvl >= LEVEL_MAX);
      rem  = hund ? (lvl - LEVEL_MAX) : lvl;
      prod = 15'(rem) * TENTH_RECIP;
      tens = prod[14:11];
      ones = rem - (7'(tens) * 7'd10);
      bcd_of = {3'b000, hund, tens, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

>>> src/remc_core.sv
// ----------------------------------------------------------------------------
// Menu state core
// Holds the menu state and computes its next value from one encoder poll.
// ----------------------------------------------------------------------------
`default_nettype none

module remc_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic                          enc_a,
   input  wire logic                          enc_b,
   input  wire logic                          push_req,
   input  wire logic [remc_pkg::COUNT_W-1:0]  half_period,
   output remc_pkg::view_type                 view_next
);
   import remc_pkg::*;

   mode_type            mode_ff,   mode_in;
   logic [LEVEL_W-1:0]  mix_ff,    mix_in;
   logic [LEVEL_W-1:0]  length_ff, length_in;
   logic [LEVEL_W-1:0]  echo_ff,   echo_in;
   logic [COUNT_W-1:0]  count_ff,  count_in;
   logic                phase_ff,  phase_in;
   logic                prev_a_ff;
   logic                prev_push_ff;
   logic                updated;

   logic                click;
   logic                ccw;
   logic                press;
   logic [COUNT_W-1:0]  count_inc;

   assign click = enc_a & ~prev_a_ff;
   assign ccw   = ~enc_b;
   assign press = push_req & ~prev_push_ff;

   function automatic logic [LEVEL_W-1:0] step_level(input logic [LEVEL_W-1:0] lvl,
                                                     input logic up);
      if (up && lvl < LEVEL_MAX) begin
         step_level = lvl + STEP_SIZE;
      end else if (!up && lvl != '0) begin
         step_level = lvl - STEP_SIZE;
      end else begin
         step_level = lvl;
      end
   endfunction

   // Next state: click first, then button press, then blink tick
   always_comb begin
      mode_in   = mode_ff;
      mix_in    = mix_ff;
      length_in = length_ff;
      echo_in   = echo_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      updated   = 1'b0;
      count_inc = '0;

      if (click) begin
         unique case (mode_ff)
            MODE_SEL_MIX: begin
               mode_in = ccw ? MODE_SEL_LENGTH : MODE_SEL_ECHO;
               count_in = '0;
               phase_in = 1'b1;
            end
            MODE_SEL_LENGTH: begin
               mode_in = ccw ? MODE_SEL_ECHO : MODE_SEL_MIX;
               count_in = '0;
               phase_in = 1'b1;
            end
            MODE_SEL_ECHO: begin
               mode_in = ccw ? MODE_SEL_MIX : MODE_SEL_LENGTH;
               count_in = '0;
               phase_in = 1'b1;
            end
            MODE_CTRL_MIX: begin
               mix_in  = step_level(mix_ff, ccw);
               updated = 1'b1;
            end
            MODE_CTRL_LENGTH: begin
               length_in = step_level(length_ff, ccw);
               updated   = 1'b1;
            end
            MODE_CTRL_ECHO: begin
               echo_in = step_level(echo_ff, ccw);
               updated = 1'b1;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end

      if (press) begin
         unique case (mode_in)
            MODE_CTRL_MIX: begin
               mode_in  = MODE_SEL_MIX;
               count_in = '0;
               phase_in = 1'b1;
            end
            MODE_SEL_MIX:    mode_in = MODE_CTRL_MIX;
            MODE_SEL_LENGTH: mode_in = MODE_CTRL_LENGTH;
            MODE_CTRL_LENGTH: begin
               mode_in  = MODE_SEL_LENGTH;
               count_in = '0;
               phase_in = 1'b1;
            end
            MODE_SEL_ECHO:   mode_in = MODE_CTRL_ECHO;
            MODE_CTRL_ECHO: begin
               mode_in  = MODE_SEL_ECHO;
               count_in = '0;
               phase_in = 1'b1;
            end
            default:         mode_in = MODE_CTRL_MIX;
         endcase
      end

      if (is_select(mode_in)) begin
         count_inc = count_in + 17'd1;
         if (count_inc >= half_period) begin
            count_in = '0;
            phase_in = ~phase_in;
         end else begin
            count_in = count_inc;
         end
      end
   end

   // Outputs: state as it stands after this poll
   always_comb begin
      view_next.mode         = mode_in;
      view_next.mix_level    = mix_in;
      view_next.length_level = length_in;
      view_next.echo_level   = echo_in;
      view_next.blink_phase  = phase_in;
      view_next.updated      = updated;
   end

   // Commit state on each transfer into the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CTRL_MIX;
         mix_ff       <= LEVEL_MIX_RST;
         length_ff    <= LEVEL_LENGTH_RST;
         echo_ff      <= LEVEL_ECHO_RST;
         count_ff     <= '0;
         phase_ff     <= 1'b1;
         prev_a_ff    <= 1'b1;
         prev_push_ff <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         mix_ff       <= mix_in;
         length_ff    <= length_in;
         echo_ff      <= echo_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         prev_a_ff    <= enc_a;
         prev_push_ff <= push_req;
      end
   end

endmodule

`default_nettype wire

>>> src/remc_format.sv
// ----------------------------------------------------------------------------
// Result formatter
// Turns the menu state into LEDs, BCD display digits and scaled settings.
// ----------------------------------------------------------------------------
`default_nettype none

module remc_format (
   input  wire remc_pkg::view_type  view,
   output remc_pkg::result_type     result
);
   import remc_pkg::*;

   logic [2:0]          led;
   logic [LEVEL_W-1:0]  shown;

   // Pick the LED and the level shown for the current parameter
   always_comb begin
      unique case (view.mode)
         MODE_CTRL_MIX, MODE_SEL_MIX: begin
            led   = LED_MIX;
            shown = view.mix_level;
         end
         MODE_SEL_LENGTH, MODE_CTRL_LENGTH: begin
            led   = LED_LENGTH;
            shown = view.length_level;
         end
         MODE_SEL_ECHO, MODE_CTRL_ECHO: begin
            led   = LED_ECHO;
            shown = view.echo_level;
         end
         default: begin
            led   = LED_OFF;
            shown = '0;
         end
      endcase
   end

   // Blank the LED in the dark half of the select-mode blink
   always_comb begin
      result.mode_code      = view.mode;
      result.led_pattern    = (is_select(view.mode) && !view.blink_phase) ? LED_OFF : led;
      result.display_bcd    = bcd_of(shown);
      result.mix_gain       = gain_of(view.mix_level);
      result.echo_gain      = gain_of(view.echo_level);
      result.delay_samples  = delay_of(view.length_level);
      result.params_updated = view.updated;
   end

endmodule

`default_nettype wire

>>> src/rotary_encoder_menu_controller_unit.sv
// ----------------------------------------------------------------------------
// Rotary encoder menu controller
// Input poll register, menu state core, formatter and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one poll of the debounced encoder A/B and push-button
//   levels per transfer (req_valid high, req_stall low). rsp_* returns one
//   result per poll: mode, LED pattern, BCD display value, mix and echo
//   gains, delay length in samples, and an update pulse for control-mode
//   clicks. csr_* writes the blink half period (polls per half period);
//   csr_ready is always high, write only while the block is idle.
//   Latency is two register stages: the poll register, then the state
//   update into the result register, which raises rsp_valid.
//   Throughput is one poll per cycle while the receiver does not stall,
//   set by the single state update path. When the receiver stalls, the
//   result register holds; an empty poll register still takes one more
//   item, then req_stall rises until the result moves.
//   Synchronous reset empties both registers, restores the menu state
//   (control mix mode, levels 50/50/0, LED blink phase on) and sets the
//   blink half period to 120000.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_menu_controller_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // poll channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_enc_a,
   input  wire logic                          req_enc_b,
   input  wire logic                          req_push_req,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_mode_code,
   output logic [2:0]                         rsp_led_pattern,
   output logic [remc_pkg::BCD_W-1:0]         rsp_display_bcd,
   output logic [remc_pkg::GAIN_W-1:0]        rsp_mix_gain,
   output logic [remc_pkg::GAIN_W-1:0]        rsp_echo_gain,
   output logic [remc_pkg::DELAY_W-1:0]       rsp_delay_samples,
   output logic                               rsp_params_updated,
   // blink half period write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [remc_pkg::COUNT_W-1:0]  csr_data
);
   import remc_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic                in_a_ff, in_b_ff, in_push_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_ff;
   logic [COUNT_W-1:0]  half_period_ff;

   logic                out_free;
   logic                fire;
   logic                req_take;
   view_type            view_next;
   result_type          result;

   // Handshake control
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the poll on each request transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_a_ff    <= req_enc_a;
         in_b_ff    <= req_enc_b;
         in_push_ff <= req_push_req;
      end
   end

   // Blink half period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= BLINK_HALF_RST;
      end else if (csr_valid && csr_ready) begin
         half_period_ff <= csr_data;
      end
   end

   remc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .enc_a       (in_a_ff),
      .enc_b       (in_b_ff),
      .push_req    (in_push_ff),
      .half_period (half_period_ff),
      .view_next   (view_next)
   );

   remc_format u_format (
      .view   (view_next),
      .result (result)
   );

   // Load the result register as the poll moves out
   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_mode_code      = out_ff.mode_code;
   assign rsp_led_pattern    = out_ff.led_pattern;
   assign rsp_display_bcd    = out_ff.display_bcd;
   assign rsp_mix_gain       = out_ff.mix_gain;
   assign rsp_echo_gain      = out_ff.echo_gain;
   assign rsp_delay_samples  = out_ff.delay_samples;
   assign rsp_params_updated = out_ff.params_updated;

   // Never overwrite a held result
   assert property (@(posedge clock) disable iff (reset)
      !(fire && out_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // At most one parameter LED lit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_led_pattern))
      else $error("more than one LED lit");

   // Display digits stay decimal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_display_bcd[3:0] <= 4'd9) && (rsp_display_bcd[7:4] <= 4'd9)
                    && (rsp_display_bcd[11:8] <= 4'd1))
      else $error("display value not BCD");

   // Control modes keep their LED solid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_code == MODE_CTRL_MIX || rsp_mode_code == MODE_CTRL_LENGTH
                    || rsp_mode_code == MODE_CTRL_ECHO) |-> (rsp_led_pattern != LED_OFF))
      else $error("control mode LED dark");

endmodule

`default_nettype wire

>>> test/rotary_encoder_menu_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Rotary encoder menu controller testbench
// Drives encoder and button polls through the request channel and checks
// every result against a cycle-free model of the menu kept in this module.
// A short scripted walk through all modes comes first. Random quadrature
// bursts, button presses and noise follow, over several blink half periods.
// Both channels idle and stall at random, and one long receiver hold-off
// backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_menu_controller_unit_tb;

   import remc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned HOLD_AT      = 400;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned RANDOM_POLLS = 300;
   localparam int unsigned PHASES       = 5;
   localparam int unsigned REPORT_MAX   = 10;

   typedef struct packed {
      logic enc_a;
      logic enc_b;
      logic push_req;
   } poll_type;

   typedef struct packed {
      poll_type   poll;
      logic       typed;
      result_type want;
   } script_row_type;

   // Results that can be read straight off the reset state
   localparam result_type AFTER_RESET = '{mode_code: MODE_CTRL_MIX, led_pattern: LED_MIX,
      display_bcd: 12'h050, mix_gain: 8'd127, echo_gain: 8'd0, delay_samples: 15'd16350,
      params_updated: 1'b0};
   localparam result_type ECHO_FLOOR = '{mode_code: MODE_CTRL_ECHO, led_pattern: LED_ECHO,
      display_bcd: 12'h000, mix_gain: 8'd127, echo_gain: 8'd0, delay_samples: 15'd16350,
      params_updated: 1'b1};
   localparam result_type NO_REF = '0;

   // Walk through every mode and most mode transitions, both click directions and the
   // lower saturation end, with click and press landing in the same poll
   localparam script_row_type SCRIPT [25] = '{
      '{'{1'b1, 1'b0, 1'b0}, 1'b1, AFTER_RESET},
      '{'{1'b0, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b1, 1'b1}, 1'b0, NO_REF},
      '{'{1'b1, 1'b0, 1'b1}, 1'b0, NO_REF},
      '{'{1'b0, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b0, 1'b1}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b0}, 1'b1, ECHO_FLOOR},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b1}, 1'b0, NO_REF},
      '{'{1'b0, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b0, 1'b1}, 1'b0, NO_REF},
      '{'{1'b1, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b0, 1'b0, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b1}, 1'b0, NO_REF},
      '{'{1'b0, 1'b1, 1'b0}, 1'b0, NO_REF},
      '{'{1'b1, 1'b1, 1'b0}, 1'b0, NO_REF}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_enc_a = 1'b0;
   logic                 req_enc_b = 1'b0;
   logic                 req_push_req = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_mode_code;
   logic [2:0]           rsp_led_pattern;
   logic [BCD_W-1:0]     rsp_display_bcd;
   logic [GAIN_W-1:0]    rsp_mix_gain;
   logic [GAIN_W-1:0]    rsp_echo_gain;
   logic [DELAY_W-1:0]   rsp_delay_samples;
   logic                 rsp_params_updated;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_data = '0;

   // Menu model state
   mode_type             menu_mode;
   logic [LEVEL_W-1:0]   mix_lvl;
   logic [LEVEL_W-1:0]   length_lvl;
   logic [LEVEL_W-1:0]   echo_lvl;
   logic [COUNT_W-1:0]   blink_cnt;
   logic                 blink_on;
   logic                 last_a;
   logic                 last_push;
   logic [COUNT_W-1:0]   half_period;

   result_type           expected_readouts [$];
   poll_type             polls_to_send [$];
   int unsigned          failures = 0;
   int unsigned          results_seen = 0;
   int unsigned          cycles = 0;
   int unsigned          stall_left = 0;
   bit                   held_off = 1'b0;
   bit                   quiet = 1'b0;

   rotary_encoder_menu_controller_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_enc_a          (req_enc_a),
      .req_enc_b          (req_enc_b),
      .req_push_req       (req_push_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode_code      (rsp_mode_code),
      .rsp_led_pattern    (rsp_led_pattern),
      .rsp_display_bcd    (rsp_display_bcd),
      .rsp_mix_gain       (rsp_mix_gain),
      .rsp_echo_gain      (rsp_echo_gain),
      .rsp_delay_samples  (rsp_delay_samples),
      .rsp_params_updated (rsp_params_updated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one; none in a quiet phase
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic in_select(input mode_type m);
      return m == MODE_SEL_MIX || m == MODE_SEL_LENGTH || m == MODE_SEL_ECHO;
   endfunction

   function automatic logic [LEVEL_W-1:0] nudge(input logic [LEVEL_W-1:0] lvl,
                                               input logic up);
      if (up && lvl < LEVEL_MAX) return lvl + STEP_SIZE;
      if (!up && lvl > 0) return lvl - STEP_SIZE;
      return lvl;
   endfunction

   task automatic clear_menu();
      menu_mode   = MODE_CTRL_MIX;
      mix_lvl     = LEVEL_MIX_RST;
      length_lvl  = LEVEL_LENGTH_RST;
      echo_lvl    = LEVEL_ECHO_RST;
      blink_cnt   = '0;
      blink_on    = 1'b1;
      last_a      = 1'b1;
      last_push   = 1'b0;
      half_period = BLINK_HALF_RST;
   endtask

   // Restart the blink with the LED lit whenever a select mode is entered
   task automatic open_select(input mode_type m);
      menu_mode = m;
      blink_cnt = '0;
      blink_on  = 1'b1;
   endtask

   // Apply one poll: click first, then button press, then blink tick
   task automatic step_menu(input poll_type p, output result_type r);
      logic               ccw;
      logic               upd;
      logic [2:0]         led;
      logic [LEVEL_W-1:0] shown;
      int unsigned        hund, tens, ones;
      upd = 1'b0;
      if (p.enc_a && !last_a) begin
         ccw = p.enc_a != p.enc_b;
         case (menu_mode)
            MODE_SEL_MIX:     open_select(ccw ? MODE_SEL_LENGTH : MODE_SEL_ECHO);
            MODE_SEL_LENGTH:  open_select(ccw ? MODE_SEL_ECHO : MODE_SEL_MIX);
            MODE_SEL_ECHO:    open_select(ccw ? MODE_SEL_MIX : MODE_SEL_LENGTH);
            MODE_CTRL_MIX: begin
               mix_lvl = nudge(mix_lvl, ccw);
               upd = 1'b1;
            end
            MODE_CTRL_LENGTH: begin
               length_lvl = nudge(length_lvl, ccw);
               upd = 1'b1;
            end
            MODE_CTRL_ECHO: begin
               echo_lvl = nudge(echo_lvl, ccw);
               upd = 1'b1;
            end
            default: ;
         endcase
      end
      last_a = p.enc_a;

      if (p.push_req && !last_push) begin
         case (menu_mode)
            MODE_CTRL_MIX:    open_select(MODE_SEL_MIX);
            MODE_SEL_MIX:     menu_mode = MODE_CTRL_MIX;
            MODE_SEL_LENGTH:  menu_mode = MODE_CTRL_LENGTH;
            MODE_CTRL_LENGTH: open_select(MODE_SEL_LENGTH);
            MODE_SEL_ECHO:    menu_mode = MODE_CTRL_ECHO;
            MODE_CTRL_ECHO:   open_select(MODE_SEL_ECHO);
            default:          menu_mode = MODE_CTRL_MIX;
         endcase
      end
      last_push = p.push_req;

      // Advance the blink counter while selecting
      if (in_select(menu_mode)) begin
         blink_cnt = blink_cnt + 1'b1;
         if (blink_cnt >= half_period) begin
            blink_cnt = '0;
            blink_on  = ~blink_on;
         end
      end

      case (menu_mode)
         MODE_CTRL_MIX, MODE_SEL_MIX: begin
            led = LED_MIX;
            shown = mix_lvl;
         end
         MODE_SEL_LENGTH, MODE_CTRL_LENGTH: begin
            led = LED_LENGTH;
            shown = length_lvl;
         end
         MODE_SEL_ECHO, MODE_CTRL_ECHO: begin
            led = LED_ECHO;
            shown = echo_lvl;
         end
         default: begin
            led = LED_OFF;
            shown = '0;
         end
      endcase
      if (in_select(menu_mode) && !blink_on) led = LED_OFF;

      hund = shown / 100;
      tens = (shown / 10) % 10;
      ones = shown % 10;
      r.mode_code      = menu_mode;
      r.led_pattern    = led;
      r.display_bcd    = {4'(hund), 4'(tens), 4'(ones)};
      r.mix_gain       = 8'((int'(mix_lvl) * 255) / 100);
      r.echo_gain      = 8'((int'(echo_lvl) * 255) / 100);
      r.delay_samples  = 15'(int'(length_lvl) * 327);
      r.params_updated = upd;
   endtask

   // Offer one poll and hold it until the block takes it
   task automatic send_poll(input poll_type p, input logic typed, input result_type want);
      int unsigned gap;
      result_type  r;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_enc_a    <= p.enc_a;
      req_enc_b    <= p.enc_b;
      req_push_req <= p.push_req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_menu(p, r);
      expected_readouts.push_back(typed ? want : r);
   endtask

   // Mostly clean quadrature bursts in one direction, plus presses and noise
   task automatic queue_random_polls(input int unsigned count);
      int unsigned made;
      int unsigned n;
      logic        dir;
      logic        level_a;
      poll_type    p;
      made = 0;
      level_a = 1'b1;
      while (made < count) begin
         n = $urandom_range(0, 99);
         if (n < 60) begin
            dir = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 12)) begin
               p.enc_a = 1'b0;
               p.enc_b = 1'($urandom_range(0, 1));
               p.push_req = 1'b0;
               polls_to_send.push_back(p);
               p.enc_a = 1'b1;
               p.enc_b = dir;
               polls_to_send.push_back(p);
               made += 2;
            end
            level_a = 1'b1;
         end else if (n < 80) begin
            p.enc_a = level_a;
            p.push_req = 1'b1;
            repeat ($urandom_range(1, 3)) begin
               p.enc_b = 1'($urandom_range(0, 1));
               polls_to_send.push_back(p);
               made++;
            end
            p.push_req = 1'b0;
            polls_to_send.push_back(p);
            made++;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               p = poll_type'(3'($urandom_range(0, 7)));
               polls_to_send.push_back(p);
               level_a = p.enc_a;
               made++;
            end
         end
      end
   endtask

   task automatic load_blink_period(input logic [COUNT_W-1:0] polls);
      csr_valid <= 1'b1;
      csr_data  <= polls;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      half_period = polls;
   endtask

   task automatic note_failure(input logic have_ref, input result_type want,
                               input result_type got);
      failures++;
      if (failures <= REPORT_MAX) begin
         if (!have_ref) begin
            $display("unexpected result at cycle %0d: %h", cycles, got);
         end else begin
            $display("mismatch at cycle %0d: mode %0d/%0d led %b/%b bcd %h/%h (exp/got)",
                     cycles, want.mode_code, got.mode_code, want.led_pattern,
                     got.led_pattern, want.display_bcd, got.display_bcd);
            $display("   mix %0d/%0d echo %0d/%0d delay %0d/%0d upd %b/%b (exp/got)",
                     want.mix_gain, got.mix_gain, want.echo_gain, got.echo_gain,
                     want.delay_samples, got.delay_samples, want.params_updated,
                     got.params_updated);
         end
      end
   endtask

   // Check each result transfer and drive the receiver stall
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_mode_code, rsp_led_pattern, rsp_display_bcd, rsp_mix_gain,
                   rsp_echo_gain, rsp_delay_samples, rsp_params_updated};
            results_seen++;
            if (expected_readouts.size() == 0)
               note_failure(1'b0, NO_REF, got);
            else if (got !== expected_readouts[0])
               note_failure(1'b1, expected_readouts.pop_front(), got);
            else
               void'(expected_readouts.pop_front());
         end
         // Hold off once for long enough to back the block up
         if (!held_off && results_seen >= HOLD_AT) begin
            held_off = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 4) == 0) stall_left = idle_len();
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned periods [PHASES];
      periods = '{1, 131071, 2, 0, 7};
      periods[3] = $urandom_range(3, 40);
      clear_menu();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Scripted walk at the reset blink period
      for (int i = 0; i < 25; i++)
         send_poll(SCRIPT[i].poll, SCRIPT[i].typed, SCRIPT[i].want);

      // Random phases, each at its own blink period
      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         while (expected_readouts.size() != 0) @(posedge clock);
         load_blink_period(COUNT_W'(periods[ph]));
         quiet = (ph == 2);
         queue_random_polls(RANDOM_POLLS);
         while (polls_to_send.size() != 0)
            send_poll(polls_to_send.pop_front(), 1'b0, NO_REF);
      end

      // Drain and leave room for stray results
      req_valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && expected_readouts.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
